// ----- hdl/lir_pkg.sv -----
// Package for the linear interpolation resampler: shared widths, constants,
// register indexes, queue entry and back-end state types.
// No dependencies.
package lir_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PHASE_W  = 21;
	localparam int FRAC_W   = 16;
	localparam int CFG_W    = 21;
	localparam int CHAN_W   = 2;

	localparam logic [PHASE_W-1:0] ONE_Q16  = 21'h010000;
	localparam logic [PHASE_W-1:0] STEP_MIN = 21'h000400;
	localparam logic [PHASE_W-1:0] STEP_MAX = 21'h100000;
	localparam logic [PHASE_W-1:0] STEP_RST = 21'h010000;

	localparam int MAX_RUN = 64;
	localparam int CNT_W   = $clog2(MAX_RUN);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [0:0] {
		REG_STEP_RATIO    = 1'b0,
		REG_CHANNELS_USED = 1'b1
	} cfg_idx_t;

	// One closed pair of input frames waiting for the back end.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] prev_left;
		logic signed [SAMPLE_W-1:0] prev_right;
		logic signed [SAMPLE_W-1:0] cur_left;
		logic signed [SAMPLE_W-1:0] cur_right;
		logic                       eot;
	} lir_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_EMIT
	} back_state_t;

endpackage

// ----- hdl/lir_queue.sv -----
// Two-entry queue of closed sample pairs between front and back end.
// Depends on lir_pkg.
module lir_queue
	import lir_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  lir_entry_t push_entry,
	input  logic       pop,
	output lir_entry_t head,
	output logic       empty,
	output logic       full
);

	lir_entry_t        entries_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
`endif

endmodule

// ----- hdl/lir_front.sv -----
// Front end: takes input frames, keeps the previous frame and pairs it with
// the current one; only closed pairs go to the queue. Depends on lir_pkg.
module lir_front
	import lir_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_left,
	input  logic signed [SAMPLE_W-1:0] sample_right,
	input  logic                       end_of_track,
	input  logic                       q_full,
	output logic                       q_push,
	output lir_entry_t                 q_entry
);

	logic signed [SAMPLE_W-1:0] prev_left_q;
	logic signed [SAMPLE_W-1:0] prev_right_q;
	logic                       have_prev_q;
	logic                       accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	// The first frame of a track only primes the pair; it causes no work.
	assign q_push   = accept && have_prev_q;

	assign q_entry.prev_left  = prev_left_q;
	assign q_entry.prev_right = prev_right_q;
	assign q_entry.cur_left   = sample_left;
	assign q_entry.cur_right  = sample_right;
	assign q_entry.eot        = end_of_track;

	always_ff @(posedge clk) begin
		if (accept) begin
			prev_left_q  <= sample_left;
			prev_right_q <= sample_right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (accept) begin
			have_prev_q <= !end_of_track;
		end
	end

endmodule

// ----- hdl/lir_back.sv -----
// Back end: owns the phase accumulator and runs the interpolation for each
// queued pair that is not skipped, one result at a time. Depends on lir_pkg.
module lir_back
	import lir_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  lir_entry_t                 head,
	input  logic                       q_empty,
	output logic                       q_pop,
	input  logic [PHASE_W-1:0]         step_ratio,
	input  logic [CHAN_W-1:0]          channels_used,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] out_left,
	output logic signed [SAMPLE_W-1:0] out_right,
	output logic                       last_of_run,
	output logic                       track_done
);

	back_state_t state_q, state_d;

	lir_entry_t          ent_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [CNT_W-1:0]    cnt_q;
	logic signed [32:0]  prod_l_s1;
	logic signed [32:0]  prod_r_s1;
	logic                last_s1;
	logic signed [SAMPLE_W-1:0] out_left_s2;
	logic signed [SAMPLE_W-1:0] out_right_s2;
	logic                last_s2;
	logic                done_s2;

	logic                mul_en;
	logic                sum_en;
	logic                skip;
	logic signed [16:0]  diff_l;
	logic signed [16:0]  diff_r;
	logic signed [16:0]  frac_s;
	logic signed [33:0]  prod_l;
	logic signed [33:0]  prod_r;
	logic [PHASE_W-1:0]  phase_nxt;
	logic                last_now;
	logic [PHASE_W-1:0]  phase_end;
	logic signed [16:0]  sum_l;
	logic signed [16:0]  sum_r;

	// A pair that arrives with the phase at or past one is skipped.
	assign skip = (phase_q >= ONE_Q16);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty && !skip) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_stall) begin
					state_d = last_s2 ? ST_IDLE : ST_MUL;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		mul_en    = 1'b0;
		sum_en    = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: q_pop     = !q_empty;
			ST_MUL:  mul_en    = 1'b1;
			ST_SUM:  sum_en    = 1'b1;
			ST_EMIT: out_valid = 1'b1;
			default: ;
		endcase
	end

	assign diff_l = {ent_q.cur_left[15], ent_q.cur_left} - {ent_q.prev_left[15], ent_q.prev_left};
	assign diff_r = {ent_q.cur_right[15], ent_q.cur_right}
		- {ent_q.prev_right[15], ent_q.prev_right};
	assign frac_s = {1'b0, phase_q[FRAC_W-1:0]};
	assign prod_l = diff_l * frac_s;
	assign prod_r = diff_r * frac_s;

	assign phase_nxt = phase_q + step_ratio;
	assign last_now  = (phase_nxt >= ONE_Q16) || (cnt_q == CNT_W'(MAX_RUN - 1));
	always_comb begin
		if (ent_q.eot || (phase_nxt < ONE_Q16)) begin
			phase_end = '0;
		end else begin
			phase_end = phase_nxt - ONE_Q16;
		end
	end

	// Arithmetic shift of the product floors the division by 2^16.
	assign sum_l = {ent_q.prev_left[15], ent_q.prev_left} + prod_l_s1[32:16];
	assign sum_r = {ent_q.prev_right[15], ent_q.prev_right} + prod_r_s1[32:16];

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= head;
		end
		if (mul_en) begin
			prod_l_s1 <= prod_l[32:0];
			prod_r_s1 <= prod_r[32:0];
			last_s1   <= last_now;
		end
		if (sum_en) begin
			out_left_s2  <= sum_l[15:0];
			out_right_s2 <= (channels_used == 2'd2) ? sum_r[15:0] : '0;
			last_s2      <= last_s1;
			done_s2      <= last_s1 && ent_q.eot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				cnt_q <= '0;
				if (skip) begin
					phase_q <= head.eot ? '0 : phase_q - ONE_Q16;
				end
			end
			if (mul_en) begin
				cnt_q   <= cnt_q + 1'b1;
				phase_q <= last_now ? phase_end : phase_nxt;
			end
		end
	end

	assign out_left    = out_left_s2;
	assign out_right   = out_right_s2;
	assign last_of_run = last_s2;
	assign track_done  = done_s2;

`ifndef SYNTHESIS
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && track_done |-> last_of_run)
		else $error("track_done without last_of_run");

	a_mul_phase_below_one: assert property (@(posedge clk) disable iff (!arst_n)
		mul_en |-> phase_q < ONE_Q16)
		else $error("interpolation step with phase at or past one");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_of_run |=> state_q == ST_IDLE)
		else $error("run continued after its last result");
`endif

endmodule

// ----- hdl/linear_interp_resampler.sv -----
// Top level of the linear interpolation resampler: configuration registers,
// front end, pair queue and back end. Depends on lir_pkg, lir_front,
// lir_queue and lir_back.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------
//   input   | in_valid / in_stall  | sample_left, sample_right, end_of_track
//   output  | out_valid / out_stall| out_left, out_right, last_of_run, track_done
//   config  | cfg_wr_en            | cfg_index, cfg_wr_data
//
// The front end takes one input transfer per cycle while the two-entry pair
// queue has room. In the back end each pair is dispatched, then each result
// runs through the multiply, add and present states, one multiply/add path
// per channel; a skipped pair is only popped and a priming frame causes none.
// A stalled output holds its result; the front keeps accepting until the
// queue fills. Reset is asynchronous and clears control state and phase.
module linear_interp_resampler
	import lir_pkg::*;
#(
	parameter int CHANNELS = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  cfg_idx_t                   cfg_index,
	input  logic [CFG_W-1:0]           cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_left,
	input  logic signed [SAMPLE_W-1:0] sample_right,
	input  logic                       end_of_track,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] out_left,
	output logic signed [SAMPLE_W-1:0] out_right,
	output logic                       last_of_run,
	output logic                       track_done
);

	logic [PHASE_W-1:0] step_q;
	logic [CHAN_W-1:0]  chan_q;
	logic [PHASE_W-1:0] step_sat;
	logic [CHAN_W-1:0]  chan_raw;
	logic [CHAN_W-1:0]  chan_sat;

	logic       q_push;
	logic       q_pop;
	logic       q_full;
	logic       q_empty;
	lir_entry_t q_in;
	lir_entry_t q_head;

	// Writes clamp to each register's range; channels uses low bits only.
	always_comb begin
		if (cfg_wr_data < STEP_MIN) begin
			step_sat = STEP_MIN;
		end else if (cfg_wr_data > STEP_MAX) begin
			step_sat = STEP_MAX;
		end else begin
			step_sat = cfg_wr_data;
		end
	end

	assign chan_raw = cfg_wr_data[CHAN_W-1:0];
	always_comb begin
		if (chan_raw == '0) begin
			chan_sat = CHAN_W'(1);
		end else if (chan_raw > CHAN_W'(CHANNELS)) begin
			chan_sat = CHAN_W'(CHANNELS);
		end else begin
			chan_sat = chan_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST;
			chan_q <= CHAN_W'(CHANNELS);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_STEP_RATIO:    step_q <= step_sat;
				REG_CHANNELS_USED: chan_q <= chan_sat;
				default: ;
			endcase
		end
	end

	lir_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.end_of_track (end_of_track),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_in)
	);

	lir_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	lir_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.step_ratio    (step_q),
		.channels_used (chan_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_left      (out_left),
		.out_right     (out_right),
		.last_of_run   (last_of_run),
		.track_done    (track_done)
	);

endmodule
